@@ sv/art_pkg.sv @@
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, codes and default sizes for the access-rights table.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned RIGHTS_BITS_DEF = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_GRANT     = 3'd0,
    CMD_DENY      = 3'd1,
    CMD_REVOKE    = 3'd2,
    CMD_LOOKUP    = 3'd3,
    CMD_CHECK     = 3'd4,
    CMD_IS_DENIED = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ sv/access_rights_table_core.sv @@
// ----------------------------------------------------------------------------
// access_rights_table_core
// Access-rights table with a sequential key search and in-place update.
// ----------------------------------------------------------------------------
// One request is taken at a time. The key search runs through the single read
// port of the key memory that feeds one shared key comparator, one entry per
// cycle, stopping at the first match. in_stall_o stays high while a request
// is in work; a finished result sits in the output register, so the next
// request may be accepted while it waits to be taken. The key and entry
// memories need no clearing after reset: only entries below the fill count
// are ever read.
`default_nettype none

module access_rights_table_core #(
  parameter int unsigned TABLE_DEPTH = art_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = art_pkg::KEY_BITS_DEF,
  parameter int unsigned RIGHTS_BITS = art_pkg::RIGHTS_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [art_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [KEY_BITS-1:0]          principal_key_i,
  input  wire logic [RIGHTS_BITS-1:0]       rights_mask_i,

  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [art_pkg::STATUS_W-1:0]      status_o,
  output logic [RIGHTS_BITS-1:0]            granted_rights_o,
  output logic                              answer_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ENT_RD,
    S_ENT_UPD,
    S_MISS,
    S_DONE
  } state_e;

  state_e               state_q;
  art_pkg::cmd_e        cmd_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [RIGHTS_BITS-1:0] mask_q;
  logic [CNT_W-1:0]     used_q;
  logic [CNT_W-1:0]     rd_idx_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     hit_idx_q;

  art_pkg::status_e     res_status_q;
  logic [RIGHTS_BITS-1:0] res_granted_q;
  logic                 res_answer_q;

  logic                 out_valid_q;
  art_pkg::status_e     status_q;
  logic [RIGHTS_BITS-1:0] granted_q;
  logic                 answer_q;

  logic [KEY_BITS-1:0]      key_mem [TABLE_DEPTH];
  logic [2*RIGHTS_BITS-1:0] ent_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0]      key_rd_q;
  logic [2*RIGHTS_BITS-1:0] ent_rd_q;

  logic                     key_we;
  logic                     ent_we;
  logic [IDX_W-1:0]         ent_waddr;
  logic [2*RIGHTS_BITS-1:0] ent_wdata;

  logic [RIGHTS_BITS-1:0]   cur_rights;
  logic [RIGHTS_BITS-1:0]   cur_denies;
  logic                     key_hit;
  logic                     table_full;
  logic                     out_free;

  assign cur_rights = ent_rd_q[RIGHTS_BITS-1:0];
  assign cur_denies = ent_rd_q[2*RIGHTS_BITS-1:RIGHTS_BITS];
  assign key_hit    = cmp_vld_q && (key_rd_q == key_q);
  assign table_full = (used_q == CNT_W'(TABLE_DEPTH));
  assign out_free   = !out_valid_q || !out_stall_i;

  // memory write control
  always_comb begin
    key_we    = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = hit_idx_q;
    ent_wdata = '0;
    case (state_q)
      S_ENT_UPD: begin
        ent_waddr = hit_idx_q;
        case (cmd_q)
          art_pkg::CMD_GRANT: begin
            ent_we    = 1'b1;
            ent_wdata = {{RIGHTS_BITS{1'b0}}, cur_rights | mask_q};
          end
          art_pkg::CMD_DENY: begin
            ent_we    = 1'b1;
            ent_wdata = {cur_denies | mask_q, cur_rights & ~mask_q};
          end
          art_pkg::CMD_REVOKE: begin
            ent_we    = 1'b1;
            ent_wdata = {cur_denies & ~mask_q, cur_rights & ~mask_q};
          end
          default: ent_we = 1'b0;
        endcase
      end
      S_MISS: begin
        ent_waddr = used_q[IDX_W-1:0];
        if (!table_full) begin
          case (cmd_q)
            art_pkg::CMD_GRANT: begin
              key_we    = 1'b1;
              ent_we    = 1'b1;
              ent_wdata = {{RIGHTS_BITS{1'b0}}, mask_q};
            end
            art_pkg::CMD_DENY: begin
              key_we    = 1'b1;
              ent_we    = 1'b1;
              ent_wdata = {mask_q, {RIGHTS_BITS{1'b0}}};
            end
            default: ent_we = 1'b0;
          endcase
        end
      end
      default: ent_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[ent_waddr] <= key_q;
    end
    key_rd_q <= key_mem[rd_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_q <= ent_mem[hit_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= art_pkg::CMD_GRANT;
      key_q         <= '0;
      mask_q        <= '0;
      used_q        <= '0;
      rd_idx_q      <= '0;
      cmp_idx_q     <= '0;
      cmp_vld_q     <= 1'b0;
      hit_idx_q     <= '0;
      res_status_q  <= art_pkg::STATUS_OK;
      res_granted_q <= '0;
      res_answer_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      status_q      <= art_pkg::STATUS_OK;
      granted_q     <= '0;
      answer_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q         <= art_pkg::cmd_e'(cmd_i);
            key_q         <= principal_key_i;
            mask_q        <= rights_mask_i;
            rd_idx_q      <= '0;
            cmp_vld_q     <= 1'b0;
            res_status_q  <= art_pkg::STATUS_OK;
            res_granted_q <= '0;
            res_answer_q  <= 1'b0;
            if (cmd_i > art_pkg::CMD_W'(art_pkg::CMD_IS_DENIED)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (key_hit) begin
            hit_idx_q <= cmp_idx_q;
            cmp_vld_q <= 1'b0;
            state_q   <= S_ENT_RD;
          end else if (rd_idx_q < used_q) begin
            cmp_vld_q <= 1'b1;
            cmp_idx_q <= rd_idx_q[IDX_W-1:0];
            rd_idx_q  <= rd_idx_q + CNT_W'(1);
          end else if (cmp_vld_q) begin
            cmp_vld_q <= 1'b0;
          end else begin
            state_q <= S_MISS;
          end
        end
        S_ENT_RD: begin
          state_q <= S_ENT_UPD;
        end
        S_ENT_UPD: begin
          case (cmd_q)
            art_pkg::CMD_LOOKUP:    res_granted_q <= cur_rights;
            art_pkg::CMD_CHECK:     res_answer_q  <= ((cur_rights & mask_q) == mask_q);
            art_pkg::CMD_IS_DENIED: res_answer_q  <= |(cur_denies & mask_q);
            default:                res_answer_q  <= 1'b0;
          endcase
          state_q <= S_DONE;
        end
        S_MISS: begin
          case (cmd_q)
            art_pkg::CMD_GRANT, art_pkg::CMD_DENY: begin
              if (table_full) begin
                res_status_q <= art_pkg::STATUS_FULL;
              end else begin
                used_q <= used_q + CNT_W'(1);
              end
            end
            art_pkg::CMD_REVOKE: res_status_q <= art_pkg::STATUS_NOT_FOUND;
            art_pkg::CMD_CHECK:  res_answer_q <= (mask_q == '0);
            default:             res_answer_q <= 1'b0;
          endcase
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            granted_q   <= res_granted_q;
            answer_q    <= res_answer_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_rights_o = granted_q;
  assign answer_o         = answer_q;

endmodule

`default_nettype wire

@@ sv/art_chk.sv @@
// ----------------------------------------------------------------------------
// art_chk
// Port-level checks for the access-rights table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module art_chk #(
  parameter int unsigned RIGHTS_BITS = art_pkg::RIGHTS_BITS_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [art_pkg::STATUS_W-1:0] status_o,
  input wire logic [RIGHTS_BITS-1:0]       granted_rights_o,
  input wire logic                         answer_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_rights_o) && $stable(answer_o))
    else $error("stalled result beat changed");

  // an accepted request is in work on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without going busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == art_pkg::STATUS_OK
      || status_o == art_pkg::STATUS_NOT_FOUND || status_o == art_pkg::STATUS_FULL)
    else $error("unused status code");

  a_granted_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_rights_o != '0 |-> status_o == art_pkg::STATUS_OK && !answer_o)
    else $error("rights reported beside an error or an answer");

  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != art_pkg::STATUS_OK |-> !answer_o)
    else $error("answer set on an error beat");

endmodule

bind access_rights_table_core art_chk #(
  .RIGHTS_BITS (RIGHTS_BITS)
) u_art_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .granted_rights_o (granted_rights_o),
  .answer_o         (answer_o)
);

`default_nettype wire

@@ dv/tb_access_rights_table_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_access_rights_table_core
// Self-checking bench for the access-rights table. A queue of directed and
// random requests feeds a clocked driver with random gaps; a mirror of the
// table predicts every reply, and a clocked monitor compares each reply field
// by field while the receiver stalls at random and, twice, for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_access_rights_table_core;

  localparam int DEPTH        = art_pkg::TABLE_DEPTH_DEF;
  localparam int KEY_W        = art_pkg::KEY_BITS_DEF;
  localparam int RIGHTS_W     = art_pkg::RIGHTS_BITS_DEF;
  localparam int N_RANDOM     = 470;
  localparam int KEY_POOL     = 80;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [art_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [art_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [art_pkg::CMD_W-1:0] cmd;
    logic [KEY_W-1:0]          key;
    logic [RIGHTS_W-1:0]       mask;
  } request_t;

  typedef struct packed {
    logic [art_pkg::STATUS_W-1:0] status;
    logic [RIGHTS_W-1:0]          granted;
    logic                         answer;
  } verdict_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid_i      = 1'b0;
  logic [art_pkg::CMD_W-1:0]    cmd_i           = '0;
  logic [KEY_W-1:0]             principal_key_i = '0;
  logic [RIGHTS_W-1:0]          rights_mask_i   = '0;
  logic                         out_stall_i     = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [art_pkg::STATUS_W-1:0] status_o;
  logic [RIGHTS_W-1:0]          granted_rights_o;
  logic                         answer_o;

  access_rights_table_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .principal_key_i  (principal_key_i),
    .rights_mask_i    (rights_mask_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_rights_o (granted_rights_o),
    .answer_o         (answer_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  logic [KEY_W-1:0]    mirror_key   [DEPTH];
  logic [RIGHTS_W-1:0] mirror_grant [DEPTH];
  logic [RIGHTS_W-1:0] mirror_deny  [DEPTH];
  int                  mirror_fill   = 0;
  int                  full_rejects  = 0;
  int                  revoke_misses = 0;

  request_t pending_requests  [$];
  verdict_t expected_verdicts [$];
  int       total_requests = 0;
  int       sent_cnt       = 0;
  int       checked_cnt    = 0;
  int       error_cnt      = 0;

  function automatic logic [art_pkg::STATUS_W-1:0] append_entry(
      logic [KEY_W-1:0] key, logic [RIGHTS_W-1:0] grant, logic [RIGHTS_W-1:0] deny);
    if (mirror_fill >= DEPTH) begin
      full_rejects++;
      return art_pkg::STATUS_FULL;
    end
    mirror_key[mirror_fill]   = key;
    mirror_grant[mirror_fill] = grant;
    mirror_deny[mirror_fill]  = deny;
    mirror_fill++;
    return art_pkg::STATUS_OK;
  endfunction

  function automatic verdict_t apply_request(request_t rq);
    verdict_t            v;
    int                  hit;
    logic [RIGHTS_W-1:0] have;
    v.status  = art_pkg::STATUS_OK;
    v.granted = '0;
    v.answer  = 1'b0;
    hit       = -1;
    for (int i = 0; i < mirror_fill; i++) begin
      if (hit < 0 && mirror_key[i] == rq.key) hit = i;
    end
    case (rq.cmd)
      art_pkg::CMD_GRANT: begin
        if (hit >= 0) begin
          mirror_grant[hit] |= rq.mask;
          mirror_deny[hit]  = '0;
        end else begin
          v.status = append_entry(rq.key, rq.mask, '0);
        end
      end
      art_pkg::CMD_DENY: begin
        if (hit >= 0) begin
          mirror_grant[hit] &= ~rq.mask;
          mirror_deny[hit]  |= rq.mask;
        end else begin
          v.status = append_entry(rq.key, '0, rq.mask);
        end
      end
      art_pkg::CMD_REVOKE: begin
        if (hit >= 0) begin
          mirror_grant[hit] &= ~rq.mask;
          mirror_deny[hit]  &= ~rq.mask;
        end else begin
          v.status = art_pkg::STATUS_NOT_FOUND;
          revoke_misses++;
        end
      end
      art_pkg::CMD_LOOKUP: begin
        if (hit >= 0) v.granted = mirror_grant[hit];
      end
      art_pkg::CMD_CHECK: begin
        have     = (hit >= 0) ? mirror_grant[hit] : '0;
        v.answer = ((have & rq.mask) == rq.mask);
      end
      art_pkg::CMD_IS_DENIED: begin
        if (hit >= 0) v.answer = |(mirror_deny[hit] & rq.mask);
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic void queue_request(logic [art_pkg::CMD_W-1:0] cmd,
                                        logic [KEY_W-1:0] key,
                                        logic [RIGHTS_W-1:0] mask);
    request_t rq;
    rq.cmd  = cmd;
    rq.key  = key;
    rq.mask = mask;
    pending_requests.push_back(rq);
  endfunction

  function automatic logic [RIGHTS_W-1:0] rand_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return RIGHTS_W'(1) << $urandom_range(0, RIGHTS_W - 1);
      3:       return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on reply %0d: %s got %h, expected %h", checked_cnt, what, got, want);
    error_cnt++;
  endtask

  // driver
  int       gap_left = 0;
  request_t cur_req;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_verdicts.push_back(apply_request({cmd_i, principal_key_i, rights_mask_i}));
        sent_cnt++;
        gap_left = (sent_cnt >= 200 && sent_cnt < 300) ? 0 : pick_gap();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          cur_req         = pending_requests.pop_front();
          in_valid_i      <= 1'b1;
          cmd_i           <= cur_req.cmd;
          principal_key_i <= cur_req.key;
          rights_mask_i   <= cur_req.mask;
        end
      end
    end
  end

  // receiver stall
  int rx_cycle   = 0;
  int stall_left = 0;
  int hold_left  = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 9000) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_cycle >= 4000 && rx_cycle < 6000) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // monitor
  verdict_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("reply with nothing pending", 32'(status_o), 32'(0));
      end else begin
        want = expected_verdicts.pop_front();
        checked_cnt++;
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (granted_rights_o !== want.granted)
          report_mismatch("granted_rights", 32'(granted_rights_o), 32'(want.granted));
        if (answer_o !== want.answer)
          report_mismatch("answer", 32'(answer_o), 32'(want.answer));
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]          key_pool [KEY_POOL];
    logic [KEY_W-1:0]          key;
    logic [RIGHTS_W-1:0]       mask;
    logic [art_pkg::CMD_W-1:0] op;
    int                        key_span;
    int                        roll;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    queue_request(art_pkg::CMD_LOOKUP,    '0, '0);
    queue_request(art_pkg::CMD_CHECK,     '0, '0);
    queue_request(art_pkg::CMD_CHECK,     '0, '1);
    queue_request(art_pkg::CMD_IS_DENIED, '0, '1);
    queue_request(art_pkg::CMD_REVOKE,    '0, '1);
    queue_request(art_pkg::CMD_GRANT,     '0, '1);
    queue_request(art_pkg::CMD_LOOKUP,    '0, '0);
    queue_request(art_pkg::CMD_CHECK,     '0, '1);
    queue_request(art_pkg::CMD_DENY,      '0, 32'h0000_FFFF);
    queue_request(art_pkg::CMD_IS_DENIED, '0, 32'h0000_0001);
    queue_request(art_pkg::CMD_CHECK,     '0, '1);
    queue_request(art_pkg::CMD_GRANT,     '0, '0);
    queue_request(art_pkg::CMD_IS_DENIED, '0, '1);
    queue_request(art_pkg::CMD_DENY,      '1, '1);
    queue_request(art_pkg::CMD_LOOKUP,    '1, '1);
    queue_request(art_pkg::CMD_IS_DENIED, '1, 32'h8000_0000);
    queue_request(art_pkg::CMD_REVOKE,    '1, 32'hAAAA_AAAA);
    queue_request(art_pkg::CMD_IS_DENIED, '1, 32'hAAAA_AAAA);
    queue_request(art_pkg::CMD_GRANT,     '1, 32'h5555_5555);
    queue_request(art_pkg::CMD_LOOKUP,    '1, '0);
    queue_request(CMD_RSVD_6,             '0, '1);
    queue_request(CMD_RSVD_7,             '1, '1);
    queue_request(art_pkg::CMD_REVOKE,    '0, '1);
    queue_request(art_pkg::CMD_LOOKUP,    '0, '1);

    for (int n = 0; n < N_RANDOM; n++) begin
      key_span = (n < 200) ? 24 : KEY_POOL;
      if ($urandom_range(0, 99) < 8) key = $urandom;
      else key = key_pool[$urandom_range(0, key_span - 1)];
      mask = rand_mask();
      roll = $urandom_range(0, 99);
      if (roll < 24)      op = art_pkg::CMD_GRANT;
      else if (roll < 38) op = art_pkg::CMD_DENY;
      else if (roll < 50) op = art_pkg::CMD_REVOKE;
      else if (roll < 64) op = art_pkg::CMD_LOOKUP;
      else if (roll < 80) op = art_pkg::CMD_CHECK;
      else if (roll < 95) op = art_pkg::CMD_IS_DENIED;
      else if (roll < 97) op = CMD_RSVD_6;
      else                op = CMD_RSVD_7;
      queue_request(op, key, mask);
      if (op == art_pkg::CMD_GRANT && $urandom_range(0, 1))
        queue_request(art_pkg::CMD_CHECK, key, mask & $urandom);
    end
    total_requests = pending_requests.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (sent_cnt < total_requests || expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests over all six commands and both spare codes; %0d replies",
             sent_cnt, checked_cnt);
    $display("table filled to %0d of %0d, %0d appends refused as full, %0d absent revokes",
             mirror_fill, DEPTH, full_rejects, revoke_misses);
    if (error_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
